// ----- design/jft_pkg.sv -----
// ----------------------------------------------------------------------------
// jft_pkg
// Widths, zone limit and per-channel coefficients of the joint friction torque
// unit. Coefs Q10.16, Coulomb/offset Q7.16; channel 6 is coupled (v4 + v5).
// ----------------------------------------------------------------------------
package jft_pkg;

  localparam int NumJoints = 6;
  localparam int NumCh     = 7;
  localparam int ChW       = 3;
  localparam int VelW      = 24;
  localparam int ChVelW    = 25;
  localparam int CoefW     = 27;
  localparam int AddW      = 24;
  localparam int ProdW     = ChVelW + CoefW;
  localparam int FracW     = 16;
  localparam int TorqW     = ProdW - FracW + 1;
  localparam int SumW      = TorqW + 1;
  localparam int OutW      = 32;

  localparam logic signed [ChVelW-1:0] VelTenth = 25'sd6553;
  localparam logic signed [ProdW-1:0]  RoundHalf = 52'sd32768;

  localparam logic signed [OutW-1:0] OutMax = 32'sh7FFF_FFFF;
  localparam logic signed [OutW-1:0] OutMin = 32'sh8000_0000;

  localparam logic [ChW-1:0] ChCoupled = 3'd6;

  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } jft_stage_en_t;

  function automatic logic signed [CoefW-1:0] coef_vis(input logic [ChW-1:0] ch);
    logic signed [CoefW-1:0] c;
    unique case (ch)
      3'd0:    c = 27'sd7287603;
      3'd1:    c = 27'sd5719982;
      3'd2:    c = 27'sd2391409;
      3'd3:    c = 27'sd628883;
      3'd4:    c = 27'sd1010565;
      3'd5:    c = 27'sd10827;
      3'd6:    c = 27'sd430178;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [CoefW-1:0] coef_neg(input logic [ChW-1:0] ch);
    logic signed [CoefW-1:0] c;
    unique case (ch)
      3'd0:    c = 27'sd30225203;
      3'd1:    c = 27'sd45088768;
      3'd2:    c = 27'sd25152717;
      3'd3:    c = 27'sd5630198;
      3'd4:    c = 27'sd3611689;
      3'd5:    c = 27'sd345047;
      3'd6:    c = 27'sd2457600;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [CoefW-1:0] coef_pos(input logic [ChW-1:0] ch);
    logic signed [CoefW-1:0] c;
    unique case (ch)
      3'd0:    c = 27'sd31509709;
      3'd1:    c = 27'sd38803866;
      3'd2:    c = 27'sd15689318;
      3'd3:    c = 27'sd5650514;
      3'd4:    c = 27'sd4631429;
      3'd5:    c = 27'sd354943;
      3'd6:    c = 27'sd2079457;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [AddW-1:0] coef_cou(input logic [ChW-1:0] ch);
    logic signed [AddW-1:0] c;
    unique case (ch)
      3'd0:    c = 24'sd2357985;
      3'd1:    c = 24'sd3622830;
      3'd2:    c = 24'sd1802895;
      3'd3:    c = 24'sd501154;
      3'd4:    c = 24'sd311099;
      3'd5:    c = 24'sd33915;
      3'd6:    c = 24'sd183828;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [AddW-1:0] coef_off(input logic [ChW-1:0] ch);
    logic signed [AddW-1:0] c;
    unique case (ch)
      3'd0:    c = 24'sd64297;
      3'd1:    c = -24'sd314180;
      3'd2:    c = -24'sd473301;
      3'd3:    c = 24'sd1026;
      3'd4:    c = 24'sd51000;
      3'd5:    c = 24'sd496;
      3'd6:    c = -24'sd18901;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- design/jft_channel.sv -----
// ----------------------------------------------------------------------------
// jft_channel
// Three-stage datapath of one friction channel: zone select, multiply,
// round to Q.16 and add Coulomb and offset terms.
// ----------------------------------------------------------------------------
module jft_channel (
  input  logic                                 clk,
  input  logic [jft_pkg::ChW-1:0]              ch,
  input  jft_pkg::jft_stage_en_t               en,
  input  logic signed [jft_pkg::ChVelW-1:0]    vel,
  output logic signed [jft_pkg::TorqW-1:0]     torque
);

  logic                                  vel_gtz;
  logic                                  zone_neg;
  logic                                  zone_pos;
  logic signed [jft_pkg::CoefW-1:0]      coef_sel;
  logic signed [jft_pkg::AddW-1:0]       add_sel;
  logic signed [jft_pkg::ChVelW-1:0]     vel_a;
  logic signed [jft_pkg::CoefW-1:0]      coef_a;
  logic signed [jft_pkg::AddW-1:0]       add_a;
  logic signed [jft_pkg::ProdW-1:0]      prod_b;
  logic signed [jft_pkg::AddW-1:0]       add_b;
  logic signed [jft_pkg::ProdW-1:0]      prod_rnd;
  logic signed [jft_pkg::TorqW-2:0]      prod_q16;
  logic signed [jft_pkg::TorqW-1:0]      torque_next;

  // Linear zones near zero speed: [-0.1, 0] and (0, 0.1]
  assign vel_gtz  = !vel[jft_pkg::ChVelW-1] && (vel != '0);
  assign zone_neg = (vel >= -jft_pkg::VelTenth) && !vel_gtz;
  assign zone_pos = vel_gtz && (vel <= jft_pkg::VelTenth);

  always_comb begin
    priority if (zone_neg) begin
      coef_sel = jft_pkg::coef_neg(ch);
      add_sel  = '0;
    end else if (zone_pos) begin
      coef_sel = jft_pkg::coef_pos(ch);
      add_sel  = '0;
    end else if (vel_gtz) begin
      coef_sel = jft_pkg::coef_vis(ch);
      add_sel  = jft_pkg::coef_off(ch) + jft_pkg::coef_cou(ch);
    end else begin
      coef_sel = jft_pkg::coef_vis(ch);
      add_sel  = jft_pkg::coef_off(ch) - jft_pkg::coef_cou(ch);
    end
  end

  always_ff @(posedge clk) begin
    if (en.a) begin
      vel_a  <= vel;
      coef_a <= coef_sel;
      add_a  <= add_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (en.b) begin
      prod_b <= jft_pkg::ProdW'(vel_a) * jft_pkg::ProdW'(coef_a);
      add_b  <= add_a;
    end
  end

  // Round half up: floor((p + 2^15) / 2^16)
  assign prod_rnd    = prod_b + jft_pkg::RoundHalf;
  assign prod_q16    = prod_rnd[jft_pkg::ProdW-1:jft_pkg::FracW];
  assign torque_next = jft_pkg::TorqW'(prod_q16) + jft_pkg::TorqW'(add_b);

  always_ff @(posedge clk) begin
    if (en.c) begin
      torque <= torque_next;
    end
  end

endmodule

// ----- design/joint_friction_torque_unit.sv -----
// ----------------------------------------------------------------------------
// joint_friction_torque_unit
// Viscous plus Coulomb joint friction torque for six joints, with a linear
// zone near zero speed and a coupled channel on joints 4 and 5.
//
// Usage:
//   Input channel: vel_valid / vel_stall with six Q7.16 joint velocities.
//   Output channel: torque_valid / torque_stall with six saturated Q15.16
//   torques. An item moves on an edge where valid is high and stall is low.
//   Stages: the accepting edge loads zone select; the item then passes in
//   order through the multiply, round and add, and combine and saturate registers.
//   Throughput: one item per cycle while torque_stall is low; each stage
//   holds one item, so the pipeline keeps taking items into empty stages
//   while a result waits. When torque_stall is held, the four stages fill
//   and vel_stall rises; no item is dropped or repeated.
//   Reset clears all stage valid bits; no result is shown until an item
//   has gone through.
// ----------------------------------------------------------------------------
module joint_friction_torque_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                vel_valid,
  output logic                                vel_stall,
  input  logic signed [jft_pkg::VelW-1:0]     velocity_joint_0,
  input  logic signed [jft_pkg::VelW-1:0]     velocity_joint_1,
  input  logic signed [jft_pkg::VelW-1:0]     velocity_joint_2,
  input  logic signed [jft_pkg::VelW-1:0]     velocity_joint_3,
  input  logic signed [jft_pkg::VelW-1:0]     velocity_joint_4,
  input  logic signed [jft_pkg::VelW-1:0]     velocity_joint_5,
  output logic                                torque_valid,
  input  logic                                torque_stall,
  output logic signed [jft_pkg::OutW-1:0]     torque_joint_0,
  output logic signed [jft_pkg::OutW-1:0]     torque_joint_1,
  output logic signed [jft_pkg::OutW-1:0]     torque_joint_2,
  output logic signed [jft_pkg::OutW-1:0]     torque_joint_3,
  output logic signed [jft_pkg::OutW-1:0]     torque_joint_4,
  output logic signed [jft_pkg::OutW-1:0]     torque_joint_5
);

  logic                                 valid_a;
  logic                                 valid_b;
  logic                                 valid_c;
  logic                                 rdy_a;
  logic                                 rdy_b;
  logic                                 rdy_c;
  logic                                 rdy_d;
  jft_pkg::jft_stage_en_t               en;
  logic signed [jft_pkg::ChVelW-1:0]    vel_ch [jft_pkg::NumCh];
  logic signed [jft_pkg::TorqW-1:0]     torq_ch [jft_pkg::NumCh];
  logic signed [jft_pkg::SumW-1:0]      sum_j [jft_pkg::NumJoints];
  logic signed [jft_pkg::OutW-1:0]      sat_j [jft_pkg::NumJoints];

  assign rdy_d     = !torque_valid || !torque_stall;
  assign rdy_c     = !valid_c || rdy_d;
  assign rdy_b     = !valid_b || rdy_c;
  assign rdy_a     = !valid_a || rdy_b;
  assign vel_stall = !rdy_a;

  assign en.a = rdy_a;
  assign en.b = rdy_b;
  assign en.c = rdy_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a      <= 1'b0;
      valid_b      <= 1'b0;
      valid_c      <= 1'b0;
      torque_valid <= 1'b0;
    end else begin
      if (rdy_a) valid_a <= vel_valid;
      if (rdy_b) valid_b <= valid_a;
      if (rdy_c) valid_c <= valid_b;
      if (rdy_d) torque_valid <= valid_c;
    end
  end

  assign vel_ch[0] = jft_pkg::ChVelW'(velocity_joint_0);
  assign vel_ch[1] = jft_pkg::ChVelW'(velocity_joint_1);
  assign vel_ch[2] = jft_pkg::ChVelW'(velocity_joint_2);
  assign vel_ch[3] = jft_pkg::ChVelW'(velocity_joint_3);
  assign vel_ch[4] = jft_pkg::ChVelW'(velocity_joint_4);
  assign vel_ch[5] = jft_pkg::ChVelW'(velocity_joint_5);
  assign vel_ch[jft_pkg::ChCoupled] = vel_ch[4] + vel_ch[5];

  for (genvar i = 0; i < jft_pkg::NumCh; i++) begin : g_ch
    jft_channel u_ch (
      .clk    (clk),
      .ch     (jft_pkg::ChW'(i)),
      .en     (en),
      .vel    (vel_ch[i]),
      .torque (torq_ch[i])
    );
  end

  for (genvar j = 0; j < jft_pkg::NumJoints; j++) begin : g_sat
    if (j >= 4) begin : g_coupled
      assign sum_j[j] = jft_pkg::SumW'(torq_ch[j]) +
                        jft_pkg::SumW'(torq_ch[jft_pkg::ChCoupled]);
    end else begin : g_plain
      assign sum_j[j] = jft_pkg::SumW'(torq_ch[j]);
    end

    always_comb begin
      priority if (sum_j[j] > jft_pkg::SumW'(jft_pkg::OutMax)) begin
        sat_j[j] = jft_pkg::OutMax;
      end else if (sum_j[j] < jft_pkg::SumW'(jft_pkg::OutMin)) begin
        sat_j[j] = jft_pkg::OutMin;
      end else begin
        sat_j[j] = sum_j[j][jft_pkg::OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      torque_joint_0 <= sat_j[0];
      torque_joint_1 <= sat_j[1];
      torque_joint_2 <= sat_j[2];
      torque_joint_3 <= sat_j[3];
      torque_joint_4 <= sat_j[4];
      torque_joint_5 <= sat_j[5];
    end
  end

  a_accept_fills_a: assert property (@(posedge clk) disable iff (rst)
    vel_valid && !vel_stall |=> valid_a)
    else $error("accepted item did not enter first stage");

  a_hold_a: assert property (@(posedge clk) disable iff (rst)
    valid_a && !rdy_b |=> valid_a)
    else $error("first stage item lost while blocked");

  a_move_c: assert property (@(posedge clk) disable iff (rst)
    valid_b && rdy_c |=> valid_c)
    else $error("second stage item did not advance");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    valid_a && valid_b && valid_c && torque_valid && torque_stall |-> vel_stall)
    else $error("input taken while pipeline full and stalled");

  a_out_from_c: assert property (@(posedge clk) disable iff (rst)
    $rose(torque_valid) |-> $past(valid_c))
    else $error("result shown without an item in last stage");

endmodule
